>>> design/ppa_pkg.sv
// Shared types and constants for the particle pool allocator.
package ppa_pkg;

  localparam int IDX_OUT_W  = 6;
  localparam int DATA_W     = 32;
  localparam int LIFE_W     = 16;
  localparam int DT_W       = 16;
  localparam int POOL_CFG_W = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [1:0] ACT_ADD  = 2'd0;
  localparam logic [1:0] ACT_TICK = 2'd1;
  localparam logic [1:0] ACT_DRAW = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_POOL_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY     = 2'd1;

  localparam logic [LIFE_W-1:0]     LIFE_FULL     = 16'd256;
  localparam logic [POOL_CFG_W-1:0] POOL_SIZE_RST = 7'd64;
  localparam logic [LIFE_W-1:0]     DECAY_RST     = 16'd256;

  typedef struct packed {
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] y;
    logic [DATA_W-1:0] size;
    logic [DATA_W-1:0] color;
  } pay_t;

  typedef struct packed {
    logic              live;
    logic [LIFE_W-1:0] aged;
  } alu_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ADD_WR,
    ST_DRAW_END
  } st_t;

endpackage

>>> design/ppa_ifs.sv
// Request, result and configuration channel interfaces.
interface ppa_in_if import ppa_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               action;
  logic signed [DATA_W-1:0] pos_x;
  logic signed [DATA_W-1:0] pos_y;
  logic [DATA_W-1:0]        size_in;
  logic [DATA_W-1:0]        color_in;
  logic [DT_W-1:0]          delta_time;

  modport source (output valid, action, pos_x, pos_y, size_in, color_in, delta_time,
                  input ready);
  modport sink   (input valid, action, pos_x, pos_y, size_in, color_in, delta_time,
                  output ready);
endinterface

interface ppa_out_if import ppa_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [IDX_OUT_W-1:0]     slot_index;
  logic signed [DATA_W-1:0] draw_x;
  logic signed [DATA_W-1:0] draw_y;
  logic [DATA_W-1:0]        draw_size;
  logic [DATA_W-1:0]        draw_color;
  logic                     particle_valid;
  logic                     last_of_run;

  modport source (output valid, slot_index, draw_x, draw_y, draw_size, draw_color,
                  particle_valid, last_of_run, input ready);
  modport sink   (input valid, slot_index, draw_x, draw_y, draw_size, draw_color,
                  particle_valid, last_of_run, output ready);
endinterface

interface ppa_cfg_if import ppa_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  idx;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, idx, data, input ready);
  modport sink   (input valid, idx, data, output ready);
endinterface

>>> design/ppa_ram.sv
// Generic simple dual-port RAM with registered read.
module ppa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

>>> design/ppa_slot_alu.sv
// Per-slot life unit: liveness test and saturating age step.
module ppa_slot_alu import ppa_pkg::*; (
  input  logic              entry_ok,
  input  logic [LIFE_W-1:0] life,
  input  logic [LIFE_W-1:0] dec,
  output alu_res_t          res
);

  always_comb begin
    res.live = entry_ok && (life != '0);
    res.aged = (life > dec) ? (life - dec) : '0;
  end

endmodule

>>> design/particle_pool_next_fit_aging_unit.sv
// Scan: n = min(pool size, POOL_DEPTH) slots, one slot read per cycle while no draw
// result waits on a busy output. Add stops early at the first free slot; tick walks all n.
// Draw: one result per live slot, or one with particle_valid low if none is live.
// One request at a time; the life RAM read port sets the one-slot-per-cycle pace.
// Reset: life valid bits cleared (all slots free), search start 0,
// pool size 64, decay 256; RAM contents are not cleared.
module particle_pool_next_fit_aging_unit import ppa_pkg::*; #(
  parameter int POOL_DEPTH = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  ppa_in_if.sink   in_ch,
  ppa_out_if.source out_ch,
  ppa_cfg_if.sink  cfg_ch
);

  localparam int IW = $clog2(POOL_DEPTH);
  localparam int CW = $clog2(POOL_DEPTH + 1);
  localparam logic [POOL_CFG_W-1:0] DEPTH_CFG = POOL_CFG_W'(POOL_DEPTH);

  // configuration
  logic [POOL_CFG_W-1:0] pool_size_r;
  logic [LIFE_W-1:0]     decay_r;

  // sequencer state
  st_t               st_r, st_nxt;
  logic [1:0]        op_r;
  pay_t              pay_in_r;
  logic [LIFE_W-1:0] dec_r;
  logic [IW-1:0]     iss_idx_r;
  logic [CW-1:0]     iss_left_r;
  logic              ph_vld_r;
  logic [IW-1:0]     ph_idx_r;
  logic [IW-1:0]     slot_r;
  logic [IW-1:0]     ss_r;
  logic              pend_vld_r;
  logic [IW-1:0]     pend_idx_r;
  pay_t              pend_pay_r;
  logic [POOL_DEPTH-1:0] lv_r;

  // output register
  logic          out_vld_r;
  logic [IW-1:0] out_slot_r;
  pay_t          out_pay_r;
  logic          out_pv_r;
  logic          out_last_r;

  // combinational
  logic [CW-1:0]         n_used;
  logic [IW-1:0]         first_idx;
  logic [CW-1:0]         idx_inc;
  logic [2*LIFE_W-1:0]   prod;
  logic                  accept;
  logic                  out_busy;
  logic [LIFE_W-1:0]     life_rdata;
  pay_t                  pay_rdata;
  alu_res_t              alu_res;
  logic                  stall, hit, adv, done, rd_en, capture;
  logic                  life_we, pay_we;
  logic [IW-1:0]         life_wa;
  logic [LIFE_W-1:0]     life_wd;
  logic                  push, push_pv, push_last;
  logic [IW-1:0]         push_slot;
  pay_t                  push_pay;

  assign n_used    = (pool_size_r > DEPTH_CFG) ? CW'(POOL_DEPTH) : CW'(pool_size_r);
  assign first_idx = (CW'(ss_r) < n_used) ? ss_r : '0;
  assign idx_inc   = CW'(iss_idx_r) + CW'(1);
  assign prod      = {{LIFE_W{1'b0}}, decay_r} * {{(2*LIFE_W-DT_W){1'b0}}, in_ch.delta_time};
  assign accept    = in_ch.valid && in_ch.ready;
  assign out_busy  = out_vld_r && !out_ch.ready;

  // configuration port
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_size_r <= POOL_SIZE_RST;
      decay_r     <= DECAY_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.idx)
        REG_POOL_SIZE: pool_size_r <= cfg_ch.data[POOL_CFG_W-1:0];
        REG_DECAY:     decay_r     <= cfg_ch.data;
        default:       ;
      endcase
    end
  end

  ppa_ram #(.WIDTH(LIFE_W), .DEPTH(POOL_DEPTH)) u_life_ram (
    .clk   (clk),
    .we    (life_we),
    .waddr (life_wa),
    .wdata (life_wd),
    .re    (rd_en),
    .raddr (iss_idx_r),
    .rdata (life_rdata)
  );

  ppa_ram #(.WIDTH($bits(pay_t)), .DEPTH(POOL_DEPTH)) u_pay_ram (
    .clk   (clk),
    .we    (pay_we),
    .waddr (slot_r),
    .wdata (pay_in_r),
    .re    (rd_en),
    .raddr (iss_idx_r),
    .rdata (pay_rdata)
  );

  ppa_slot_alu u_alu (
    .entry_ok (lv_r[ph_idx_r]),
    .life     (life_rdata),
    .dec      (dec_r),
    .res      (alu_res)
  );

  // sequencer outputs
  always_comb begin
    in_ch.ready = 1'b0;
    stall       = 1'b0;
    hit         = 1'b0;
    adv         = 1'b0;
    done        = 1'b0;
    rd_en       = 1'b0;
    capture     = 1'b0;
    life_we     = 1'b0;
    life_wa     = ph_idx_r;
    life_wd     = alu_res.aged;
    pay_we      = 1'b0;
    push        = 1'b0;
    push_slot   = pend_idx_r;
    push_pay    = pend_pay_r;
    push_pv     = 1'b1;
    push_last   = 1'b0;
    case (st_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
      end
      ST_SCAN: begin
        stall   = (op_r == ACT_DRAW) && ph_vld_r && alu_res.live && pend_vld_r && out_busy;
        hit     = (op_r == ACT_ADD) && ph_vld_r && !alu_res.live;
        adv     = !stall && !hit;
        rd_en   = adv && (iss_left_r != '0);
        done    = adv && (iss_left_r == '0);
        life_we = (op_r == ACT_TICK) && ph_vld_r && alu_res.live;
        capture = (op_r == ACT_DRAW) && ph_vld_r && alu_res.live && !stall;
        // previous live slot goes out once a later one is known
        push    = capture && pend_vld_r;
      end
      ST_ADD_WR: begin
        life_wa   = slot_r;
        life_wd   = LIFE_FULL;
        life_we   = !out_busy;
        pay_we    = !out_busy;
        push      = !out_busy;
        push_slot = slot_r;
        push_pay  = '0;
        push_pv   = 1'b0;
        push_last = 1'b1;
      end
      ST_DRAW_END: begin
        push      = !out_busy;
        push_slot = pend_vld_r ? pend_idx_r : '0;
        push_pay  = pend_vld_r ? pend_pay_r : '0;
        push_pv   = pend_vld_r;
        push_last = 1'b1;
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          case (in_ch.action)
            ACT_ADD, ACT_TICK, ACT_DRAW: st_nxt = ST_SCAN;
            default:                     st_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        if (hit) begin
          st_nxt = ST_ADD_WR;
        end else if (done) begin
          case (op_r)
            ACT_ADD:  st_nxt = ST_ADD_WR;
            ACT_DRAW: st_nxt = ST_DRAW_END;
            default:  st_nxt = ST_IDLE;
          endcase
        end
      end
      ST_ADD_WR, ST_DRAW_END: begin
        if (!out_busy) begin
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= ST_IDLE;
      op_r       <= ACT_ADD;
      ph_vld_r   <= 1'b0;
      pend_vld_r <= 1'b0;
      ss_r       <= '0;
      iss_left_r <= '0;
      lv_r       <= '0;
    end else begin
      st_r <= st_nxt;
      if (accept) begin
        op_r       <= in_ch.action;
        // only the free search starts at the remembered point; tick and draw walk from 0
        iss_idx_r  <= (in_ch.action == ACT_ADD) ? first_idx : '0;
        iss_left_r <= n_used;
        ph_vld_r   <= 1'b0;
        pend_vld_r <= 1'b0;
        slot_r     <= '0;  // pool full falls back to slot 0
      end
      if (st_r == ST_SCAN) begin
        if (!stall) begin
          ph_vld_r <= rd_en;
        end
        if (rd_en) begin
          ph_idx_r   <= iss_idx_r;
          iss_idx_r  <= (idx_inc == n_used) ? '0 : idx_inc[IW-1:0];
          iss_left_r <= iss_left_r - CW'(1);
        end
        if (hit) begin
          slot_r <= ph_idx_r;
          ss_r   <= ph_idx_r;
        end
        if (capture) begin
          pend_vld_r <= 1'b1;
          pend_idx_r <= ph_idx_r;
          pend_pay_r <= pay_rdata;
        end
      end
      if (st_r == ST_DRAW_END && push) begin
        pend_vld_r <= 1'b0;
      end
      if (life_we) begin
        lv_r[life_wa] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pay_in_r <= '{x: in_ch.pos_x, y: in_ch.pos_y, size: in_ch.size_in,
                    color: in_ch.color_in};
      dec_r    <= prod[2*LIFE_W-1:LIFE_W];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= push || (out_vld_r && !out_ch.ready);
    end
    if (push) begin
      out_slot_r <= push_slot;
      out_pay_r  <= push_pay;
      out_pv_r   <= push_pv;
      out_last_r <= push_last;
    end
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.slot_index     = IDX_OUT_W'(out_slot_r);
  assign out_ch.draw_x         = out_pay_r.x;
  assign out_ch.draw_y         = out_pay_r.y;
  assign out_ch.draw_size      = out_pay_r.size;
  assign out_ch.draw_color     = out_pay_r.color;
  assign out_ch.particle_valid = out_pv_r;
  assign out_ch.last_of_run    = out_last_r;

`ifndef SYNTHESIS
  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !out_busy)
    else $error("result pushed into a stalled output register");

  a_pend_draw: assert property (@(posedge clk) disable iff (!rst_n)
    pend_vld_r |-> (op_r == ACT_DRAW))
    else $error("held draw result outside a draw scan");

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> (!ph_vld_r && !pend_vld_r))
    else $error("scan state left over when accepting a request");

  a_valid_set: assert property (@(posedge clk) disable iff (!rst_n)
    life_we |=> lv_r[$past(life_wa)])
    else $error("life write did not mark the slot valid");
`endif

endmodule

>>> test/particle_pool_next_fit_aging_unit_test.sv
// Testbench for the particle pool next-fit allocator: directed table, random phases, scoreboard.
`timescale 1ns / 100ps

module particle_pool_next_fit_aging_unit_test;
  import ppa_pkg::*;

  localparam int POOL_DEPTH  = 64;
  localparam int SETTLE      = POOL_DEPTH + 8;  // worst request latency plus margin
  localparam int HOLD_CYCLES = 400;
  localparam int RUN_LIMIT   = 1000000;
  localparam int PHASES      = 8;
  localparam int PER_PHASE   = 42;

  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]               action;
    logic signed [DATA_W-1:0] pos_x;
    logic signed [DATA_W-1:0] pos_y;
    logic [DATA_W-1:0]        size_in;
    logic [DATA_W-1:0]        color_in;
    logic [DT_W-1:0]          delta_time;
  } pool_req_t;

  typedef struct packed {
    logic [IDX_OUT_W-1:0] slot;
    logic [DATA_W-1:0]    x;
    logic [DATA_W-1:0]    y;
    logic [DATA_W-1:0]    side;
    logic [DATA_W-1:0]    rgba;
    logic                 live;
    logic                 run_end;
  } slot_report_t;

  typedef enum logic {ROW_REQUEST, ROW_REGISTER} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    pool_req_t             req;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_data;
    bit                    has_fixed;
    logic [IDX_OUT_W-1:0]  fixed_slot;
  } table_row_t;

  logic clk = 1'b0;
  logic rst_n;

  ppa_in_if  in_ch ();
  ppa_out_if out_ch ();
  ppa_cfg_if cfg_ch ();

  particle_pool_next_fit_aging_unit #(.POOL_DEPTH(POOL_DEPTH)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow of the pool state
  logic [LIFE_W-1:0]     slot_life [POOL_DEPTH];
  logic [DATA_W-1:0]     slot_x    [POOL_DEPTH];
  logic [DATA_W-1:0]     slot_y    [POOL_DEPTH];
  logic [DATA_W-1:0]     slot_side [POOL_DEPTH];
  logic [DATA_W-1:0]     slot_rgba [POOL_DEPTH];
  logic [IDX_OUT_W-1:0]  fit_start;
  logic [POOL_CFG_W-1:0] pool_limit;
  logic [LIFE_W-1:0]     decay_q88;

  slot_report_t slot_reports_due[$];
  table_row_t   directed_rows[$];

  int  fail_count      = 0;
  int  reports_checked = 0;
  int  settings_used   = 1;
  int  action_count[4] = '{0, 0, 0, 0};
  int  cycle_count     = 0;
  bit  no_idle         = 1'b0;
  bit  hold_results    = 1'b0;

  int phase_pool [PHASES] = '{64, 7, 1, 0, 127, 33, 2, 64};
  int phase_decay[PHASES] = '{256, 40, 0, 65535, 0, 700, 128, 3000};

  // Applies one request to the shadow pool and queues the slot reports it should produce.
  task automatic predict_pool(input pool_req_t r, input bit has_fixed,
                              input logic [IDX_OUT_W-1:0] fixed_slot);
    slot_report_t rep;
    slot_report_t reps[$];
    int n;
    int pick;
    int wrap_end;
    logic [31:0] dec;
    n = (pool_limit > POOL_DEPTH) ? POOL_DEPTH : int'(pool_limit);
    case (r.action)
      ACT_ADD: begin
        pick = -1;
        wrap_end = (int'(fit_start) < n) ? int'(fit_start) : n;
        for (int i = fit_start; i < n; i++)
          if (pick < 0 && slot_life[i] == '0) pick = i;
        for (int i = 0; i < wrap_end; i++)
          if (pick < 0 && slot_life[i] == '0) pick = i;
        // pool full: slot 0 is reused and the start point stays put
        if (pick >= 0) fit_start = pick[IDX_OUT_W-1:0];
        else pick = 0;
        slot_life[pick] = LIFE_FULL;
        slot_x[pick]    = r.pos_x;
        slot_y[pick]    = r.pos_y;
        slot_side[pick] = r.size_in;
        slot_rgba[pick] = r.color_in;
        rep = '0;
        rep.slot = pick[IDX_OUT_W-1:0];
        reps.push_back(rep);
      end
      ACT_TICK: begin
        dec = ({16'd0, decay_q88} * {16'd0, r.delta_time}) >> 16;
        for (int i = 0; i < n; i++)
          if (slot_life[i] != '0)
            slot_life[i] = ({16'd0, slot_life[i]} > dec) ? slot_life[i] - dec[LIFE_W-1:0] : '0;
      end
      ACT_DRAW: begin
        for (int i = 0; i < n; i++) begin
          if (slot_life[i] != '0) begin
            rep.slot    = i[IDX_OUT_W-1:0];
            rep.x       = slot_x[i];
            rep.y       = slot_y[i];
            rep.side    = slot_side[i];
            rep.rgba    = slot_rgba[i];
            rep.live    = 1'b1;
            rep.run_end = 1'b0;
            reps.push_back(rep);
          end
        end
        if (reps.size() == 0) begin
          rep = '0;
          reps.push_back(rep);
        end
      end
      default: ;
    endcase
    if (reps.size() != 0) reps[reps.size()-1].run_end = 1'b1;
    if (has_fixed) begin
      rep = '0;
      rep.slot = fixed_slot;
      rep.run_end = 1'b1;
      reps.delete();
      reps.push_back(rep);
    end
    foreach (reps[i]) slot_reports_due.push_back(reps[i]);
  endtask

  task automatic send_request(input pool_req_t r, input bit has_fixed,
                              input logic [IDX_OUT_W-1:0] fixed_slot);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.action     <= r.action;
    in_ch.pos_x      <= r.pos_x;
    in_ch.pos_y      <= r.pos_y;
    in_ch.size_in    <= r.size_in;
    in_ch.color_in   <= r.color_in;
    in_ch.delta_time <= r.delta_time;
    in_ch.valid      <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    predict_pool(r, has_fixed, fixed_slot);
    action_count[r.action]++;
  endtask

  // Drain outstanding reports, then give ticks and ignored requests time to finish.
  task automatic settle_block();
    in_ch.valid <= 1'b0;
    while (slot_reports_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_ch.idx   <= idx;
    cfg_ch.data  <= data;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == REG_POOL_SIZE) pool_limit = data[POOL_CFG_W-1:0];
    else if (idx == REG_DECAY) decay_q88 = data;
    settings_used++;
    @(posedge clk);
  endtask

  function automatic table_row_t req_row(input logic [1:0] action, input logic [31:0] px,
                                         input logic [31:0] py, input logic [31:0] side,
                                         input logic [31:0] rgba, input logic [15:0] dt,
                                         input bit has_fixed, input logic [5:0] fixed_slot);
    table_row_t row;
    row.kind       = ROW_REQUEST;
    row.req        = '{action, px, py, side, rgba, dt};
    row.reg_idx    = '0;
    row.reg_data   = '0;
    row.has_fixed  = has_fixed;
    row.fixed_slot = fixed_slot;
    return row;
  endfunction

  function automatic table_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
    table_row_t row;
    row.kind       = ROW_REGISTER;
    row.req        = '0;
    row.reg_idx    = idx;
    row.reg_data   = data;
    row.has_fixed  = 1'b0;
    row.fixed_slot = '0;
    return row;
  endfunction

  function automatic pool_req_t random_request();
    pool_req_t r;
    int pick;
    pick = $urandom_range(0, 99);
    r.action = (pick < 45) ? ACT_ADD : (pick < 67) ? ACT_TICK :
               (pick < 94) ? ACT_DRAW : ACT_UNUSED;
    r.pos_x    = $urandom;
    r.pos_y    = $urandom;
    r.size_in  = $urandom;
    r.color_in = $urandom;
    case ($urandom_range(0, 3))
      0, 1:    r.delta_time = DT_W'($urandom_range(0, 16'h07FF));
      2:       r.delta_time = DT_W'($urandom);
      default: r.delta_time = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    endcase
    return r;
  endfunction

  function automatic void build_directed();
    // reset state: empty draw, tick on an empty pool, adds with extreme payloads
    directed_rows.push_back(req_row(ACT_DRAW, 0, 0, 0, 0, 0, 1'b1, 6'd0));
    directed_rows.push_back(req_row(ACT_TICK, 0, 0, 0, 0, 16'hFFFF, 1'b0, 6'd0));
    directed_rows.push_back(req_row(ACT_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                                    32'h0000_0000, 16'h0000, 1'b1, 6'd0));
    directed_rows.push_back(req_row(ACT_ADD, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000,
                                    32'hFFFF_FFFF, 16'hFFFF, 1'b1, 6'd1));
    directed_rows.push_back(req_row(ACT_DRAW, 0, 0, 0, 0, 0, 1'b0, 6'd0));
    // decrement truncates to zero
    directed_rows.push_back(req_row(ACT_TICK, 0, 0, 0, 0, 16'h00FF, 1'b0, 6'd0));
    directed_rows.push_back(req_row(ACT_UNUSED, '1, '1, '1, '1, '1, 1'b0, 6'd0));
    directed_rows.push_back(req_row(ACT_TICK, 0, 0, 0, 0, 16'hFFFF, 1'b0, 6'd0));
    directed_rows.push_back(req_row(ACT_DRAW, 0, 0, 0, 0, 0, 1'b0, 6'd0));
    directed_rows.push_back(req_row(ACT_TICK, 0, 0, 0, 0, 16'h0100, 1'b0, 6'd0));
    directed_rows.push_back(req_row(ACT_DRAW, 0, 0, 0, 0, 0, 1'b1, 6'd0));
    // three slots: next fit, wrap, then pool full
    directed_rows.push_back(reg_row(REG_POOL_SIZE, 16'd3));
    directed_rows.push_back(req_row(ACT_ADD, 32'h1, 32'h2, 32'h3, 32'h4, 0, 1'b1, 6'd1));
    directed_rows.push_back(req_row(ACT_ADD, 32'h5, 32'h6, 32'h7, 32'h8, 0, 1'b1, 6'd2));
    directed_rows.push_back(req_row(ACT_ADD, 32'h9, 32'hA, 32'hB, 32'hC, 0, 1'b1, 6'd0));
    directed_rows.push_back(req_row(ACT_ADD, 32'hD, 32'hE, 32'hF, 32'h10, 0, 1'b1, 6'd0));
    // no slots in use
    directed_rows.push_back(reg_row(REG_POOL_SIZE, 16'd0));
    directed_rows.push_back(req_row(ACT_ADD, 32'h11, 32'h12, 32'h13, 32'h14, 0, 1'b1, 6'd0));
    directed_rows.push_back(req_row(ACT_DRAW, 0, 0, 0, 0, 0, 1'b1, 6'd0));
    directed_rows.push_back(req_row(ACT_TICK, 0, 0, 0, 0, 16'h1234, 1'b0, 6'd0));
    // size above the pool depth
    directed_rows.push_back(reg_row(REG_POOL_SIZE, 16'd100));
    directed_rows.push_back(req_row(ACT_ADD, 32'h21, 32'h22, 32'h23, 32'h24, 0, 1'b1, 6'd3));
    directed_rows.push_back(req_row(ACT_DRAW, 0, 0, 0, 0, 0, 1'b0, 6'd0));
    // start point beyond the size in use
    directed_rows.push_back(reg_row(REG_POOL_SIZE, 16'd2));
    directed_rows.push_back(req_row(ACT_ADD, 32'h31, 32'h32, 32'h33, 32'h34, 0, 1'b1, 6'd0));
    directed_rows.push_back(req_row(ACT_DRAW, 0, 0, 0, 0, 0, 1'b0, 6'd0));
    // max decay wipes every slot; upper data bits of the size register are dropped
    directed_rows.push_back(reg_row(REG_DECAY, 16'hFFFF));
    directed_rows.push_back(reg_row(REG_POOL_SIZE, 16'hFFC0));
    directed_rows.push_back(req_row(ACT_TICK, 0, 0, 0, 0, 16'hFFFF, 1'b0, 6'd0));
    directed_rows.push_back(req_row(ACT_DRAW, 0, 0, 0, 0, 0, 1'b1, 6'd0));
    directed_rows.push_back(req_row(ACT_ADD, 32'h41, 32'h42, 32'h43, 32'h44, 0, 1'b1, 6'd3));
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      fail_count++;
    end
  endtask

  // Result scoreboard
  always @(posedge clk) begin
    slot_report_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (slot_reports_due.size() == 0) begin
        $error("slot report %0d arrived with no request outstanding", out_ch.slot_index);
        fail_count++;
      end else begin
        want = slot_reports_due.pop_front();
        check_field("slot_index", want.slot, out_ch.slot_index);
        check_field("draw_x", want.x, out_ch.draw_x);
        check_field("draw_y", want.y, out_ch.draw_y);
        check_field("draw_size", want.side, out_ch.draw_size);
        check_field("draw_color", want.rgba, out_ch.draw_color);
        check_field("particle_valid", want.live, out_ch.particle_valid);
        check_field("last_of_run", want.run_end, out_ch.last_of_run);
        reports_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == RUN_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result-side back-pressure
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_results) begin
        hold_results = 1'b0;
        stall = HOLD_CYCLES;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 5);
      end
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid && !hold_results);
    end
  end

  initial begin
    pool_req_t r;
    int counted;
    for (int i = 0; i < POOL_DEPTH; i++) begin
      slot_life[i] = '0;
      slot_x[i]    = '0;
      slot_y[i]    = '0;
      slot_side[i] = '0;
      slot_rgba[i] = '0;
    end
    fit_start  = '0;
    pool_limit = POOL_SIZE_RST;
    decay_q88  = DECAY_RST;
    build_directed();

    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.action     <= ACT_ADD;
    in_ch.pos_x      <= '0;
    in_ch.pos_y      <= '0;
    in_ch.size_in    <= '0;
    in_ch.color_in   <= '0;
    in_ch.delta_time <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.idx       <= REG_POOL_SIZE;
    cfg_ch.data      <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_REGISTER) begin
        settle_block();
        write_register(directed_rows[i].reg_idx, directed_rows[i].reg_data);
      end else begin
        send_request(directed_rows[i].req, directed_rows[i].has_fixed,
                     directed_rows[i].fixed_slot);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      settle_block();
      write_register(REG_POOL_SIZE,
                     CFG_DATA_W'(($urandom & 32'hFF80) | phase_pool[p]));
      write_register(REG_DECAY, CFG_DATA_W'(phase_decay[p]));
      no_idle = (p == 2 || p == 5);
      counted = 0;
      while (counted < PER_PHASE) begin
        // long result stall mid-phase so the block backs up onto its request port
        if (p == 0 && counted == 12) hold_results = 1'b1;
        r = random_request();
        send_request(r, 1'b0, '0);
        if (r.action != ACT_UNUSED) counted++;
      end
    end

    settle_block();
    $display("%0d requests: %0d add, %0d tick, %0d draw, %0d unused action",
             action_count[0] + action_count[1] + action_count[2] + action_count[3],
             action_count[0], action_count[1], action_count[2], action_count[3]);
    $display("%0d slot reports checked over %0d register settings",
             reports_checked, settings_used);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
design/ppa_pkg.sv
design/ppa_ifs.sv
design/ppa_ram.sv
design/ppa_slot_alu.sv
design/particle_pool_next_fit_aging_unit.sv
test/particle_pool_next_fit_aging_unit_test.sv
